// ===== hdl/lfd_pkg.sv =====
package lfd_pkg;

  // Result kind codes.
  localparam logic [2:0] KIND_OTHER   = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_GOOD    = 3'd2;
  localparam logic [2:0] KIND_BAD     = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  // Input kind codes.
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_TAG     = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd1000;
  localparam logic [3:0]  TAG_RST     = 4'd8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int MAX_FRAME_DEF = 4096;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [12:0] len;
    logic        last;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/long_frame_deframer_crc16.sv =====
// Channel | Direction | Ports                                         | Handshake
// in      | input     | in_kind, in_rx_byte                           | in_valid / in_ready
// out     | output    | out_kind, out_byte, out_frame_length,
//         |           | out_last_of_run                               | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_data                           | cfg_valid / cfg_ready
//
// One request is taken per cycle while in_ready is high. An accepted request sits in the
// input register, where a single pass of logic (the byte-wide CRC update and the frame state
// machine) turns it into at most two results. These go into a four-entry result queue, which
// drives the output, so each result passes the input register and then the queue. The input
// register only advances while the queue has room for two results; a stalled output therefore
// backs up into in_ready once the queue fills. Reset is synchronous and active low; it returns the
// receiver to idle, empties the queue and loads the register defaults. cfg_ready is always high.
module long_frame_deframer_crc16
  import lfd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [12:0] out_frame_length,
  output logic        out_last_of_run,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CRC     = 2'd3;

  localparam logic [12:0] MAX_LEN = 13'(MAX_FRAME);

  // Configuration registers.
  logic [31:0] frame_timeout_r;
  logic [3:0]  frame_tag_r;

  // Input register.
  logic        st_valid_r;
  logic        st_kind_r;
  logic [7:0]  st_byte_r;

  // Receiver state.
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [12:0] exp_len_r, exp_len_nxt;
  logic [12:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [31:0] idle_ticks_r, idle_ticks_nxt;

  // Result queue.
  result_t     queue_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;

  logic        stage_fire;
  logic        pop;
  logic        drop_to;
  logic [1:0]  ph;
  logic [15:0] crc_cur;
  logic [12:0] exp_cur;
  logic [12:0] cnt_cur;
  logic [12:0] hdr_len;
  logic [15:0] crc_fold;
  logic        main_v;
  result_t     main_res;
  result_t     res0, res1;
  logic        push0, push1;
  logic [1:0]  n_push;

  assign cfg_ready = 1'b1;

  // The stage only fires when two queue slots are certainly free.
  assign stage_fire = st_valid_r && (count_r <= 3'd2);
  assign in_ready   = !st_valid_r || stage_fire;
  assign pop        = out_valid && out_ready;

  // Frame state machine and CRC, one pass per request.
  always_comb begin
    drop_to  = (st_kind_r == IN_BYTE) && (phase_r != PH_IDLE) &&
               (idle_ticks_r > frame_timeout_r);
    // A timeout abandons the frame before the byte itself is handled.
    ph       = drop_to ? PH_IDLE : phase_r;
    crc_cur  = drop_to ? CRC_INIT : crc_r;
    exp_cur  = drop_to ? 13'd0 : exp_len_r;
    cnt_cur  = drop_to ? 13'd0 : rcv_cnt_r;

    hdr_len  = (exp_len_r | {5'd0, st_byte_r}) + 13'd1;
    crc_fold = crc_r ^ {8'h00, st_byte_r};

    phase_nxt      = phase_r;
    crc_nxt        = crc_r;
    exp_len_nxt    = exp_len_r;
    rcv_cnt_nxt    = rcv_cnt_r;
    idle_ticks_nxt = idle_ticks_r;
    main_v         = 1'b0;
    main_res       = '{kind: KIND_OTHER, data: 8'h00, len: 13'd0, last: 1'b1};

    if (st_kind_r == IN_TICK) begin
      if (idle_ticks_r != '1) begin
        idle_ticks_nxt = idle_ticks_r + 32'd1;
      end
    end else begin
      idle_ticks_nxt = '0;
      phase_nxt      = ph;
      crc_nxt        = crc_cur;
      exp_len_nxt    = exp_cur;
      rcv_cnt_nxt    = cnt_cur;
      unique case (ph)
        PH_IDLE: begin
          if (st_byte_r[7:4] == frame_tag_r) begin
            crc_nxt     = crc_byte(CRC_INIT, st_byte_r);
            exp_len_nxt = {1'b0, st_byte_r[3:0], 8'h00};
            rcv_cnt_nxt = '0;
            phase_nxt   = PH_HEADER;
          end else begin
            main_v        = 1'b1;
            main_res.kind = KIND_OTHER;
            main_res.data = st_byte_r;
          end
        end
        PH_HEADER: begin
          rcv_cnt_nxt = '0;
          if (hdr_len > MAX_LEN) begin
            // Oversized length: report a drop with zero length.
            main_v        = 1'b1;
            main_res.kind = KIND_DROP;
            phase_nxt     = PH_IDLE;
            crc_nxt       = CRC_INIT;
            exp_len_nxt   = '0;
          end else begin
            crc_nxt     = crc_byte(crc_r, st_byte_r);
            exp_len_nxt = hdr_len;
            phase_nxt   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (rcv_cnt_r >= exp_len_r) begin
            // First CRC byte folds into the high half.
            crc_nxt   = crc_r ^ {st_byte_r, 8'h00};
            phase_nxt = PH_CRC;
          end else begin
            crc_nxt       = crc_byte(crc_r, st_byte_r);
            rcv_cnt_nxt   = rcv_cnt_r + 13'd1;
            main_v        = 1'b1;
            main_res.kind = KIND_PAYLOAD;
            main_res.data = st_byte_r;
          end
        end
        PH_CRC: begin
          main_v        = 1'b1;
          main_res.kind = (crc_fold == 16'h0000) ? KIND_GOOD : KIND_BAD;
          main_res.len  = rcv_cnt_r;
          phase_nxt     = PH_IDLE;
          crc_nxt       = CRC_INIT;
          exp_len_nxt   = '0;
          rcv_cnt_nxt   = '0;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Order the results: a timeout drop always comes first.
    if (drop_to) begin
      res0   = '{kind: KIND_DROP, data: 8'h00, len: rcv_cnt_r, last: !main_v};
      res1   = main_res;
      push0  = stage_fire;
      push1  = stage_fire && main_v;
    end else begin
      res0   = main_res;
      res1   = main_res;
      push0  = stage_fire && main_v;
      push1  = 1'b0;
    end
    n_push = {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_timeout_r <= TIMEOUT_RST;
      frame_tag_r     <= TAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT: frame_timeout_r <= cfg_data;
        CFG_TAG:     frame_tag_r     <= cfg_data[3:0];
        default:     frame_tag_r     <= frame_tag_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_kind_r <= in_kind;
      st_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      crc_r        <= CRC_INIT;
      exp_len_r    <= '0;
      rcv_cnt_r    <= '0;
      idle_ticks_r <= '0;
    end else if (stage_fire) begin
      phase_r      <= phase_nxt;
      crc_r        <= crc_nxt;
      exp_len_r    <= exp_len_nxt;
      rcv_cnt_r    <= rcv_cnt_nxt;
      idle_ticks_r <= idle_ticks_nxt;
    end
  end

  // Queue storage; the second result goes in the slot after the first.
  always_ff @(posedge clk) begin
    if (push0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push1) begin
      queue_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + {1'b0, n_push} - {2'd0, pop};
    end
  end

  assign out_valid        = (count_r != 3'd0);
  assign out_kind         = queue_r[rd_ptr_r].kind;
  assign out_byte         = queue_r[rd_ptr_r].data;
  assign out_frame_length = queue_r[rd_ptr_r].len;
  assign out_last_of_run  = queue_r[rd_ptr_r].last;

endmodule
